// ===== sv/vorbis_comment_tag_extractor_assert.svh =====
// Assertion macros used by the checker file of the tag extractor.
`ifndef VORBIS_COMMENT_TAG_EXTRACTOR_ASSERT_SVH
`define VORBIS_COMMENT_TAG_EXTRACTOR_ASSERT_SVH

// Condition checked at every rising clock edge outside reset.
`define VCT_CHECK(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define VCT_CHECK_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/vct_pkg.sv =====
// Shared types and constants of the Vorbis comment tag extractor.
package vct_pkg;

    typedef enum logic [1:0] {
        TAG_NONE   = 2'd0,
        TAG_TITLE  = 2'd1,
        TAG_ARTIST = 2'd2,
        TAG_ALBUM  = 2'd3
    } t_tag_kind;

    localparam logic STATUS_FULL  = 1'b0;
    localparam logic STATUS_TRUNC = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        t_tag_kind  tag_kind;
        logic [7:0] value_byte;
        logic       value_last;
        logic       block_done;
        logic       parse_status;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

// ===== sv/vorbis_comment_tag_extractor.sv =====
// Top level of the Vorbis comment tag extractor.
// The block takes one byte of a Vorbis comment block per cycle and parses it in the
// same cycle; its results go into a four-entry result queue that hands out one
// transaction per cycle. Input is ready whenever the queue has two free entries, so
// with the output side always ready the rate is one byte per cycle; the byte that
// ends a block can give both a value result and a done result.
// Write block_size only while the block is idle.
module vorbis_comment_tag_extractor #(
    parameter int TAG_CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_block_size,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_tag_kind,
    output logic [7:0]  o_value_byte,
    output logic        o_value_last,
    output logic        o_block_done,
    output logic        o_parse_status
);

    logic [23:0]      r_block_size;
    logic             take;
    logic             space;
    vct_pkg::t_push   push;
    vct_pkg::t_result head;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = space;
    assign take        = i_in_valid && space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= 24'd0;
        end else if (i_cfg_valid) begin
            r_block_size <= i_cfg_block_size;
        end
    end

    vct_parser #(
        .TAG_CAPACITY (TAG_CAPACITY)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_data_byte  (i_data_byte),
        .i_block_size (r_block_size),
        .o_push       (push)
    );

    vct_out_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop_ready (i_out_ready),
        .o_valid     (o_out_valid),
        .o_result    (head),
        .o_space     (space)
    );

    assign o_tag_kind     = head.tag_kind;
    assign o_value_byte   = head.value_byte;
    assign o_value_last   = head.value_last;
    assign o_block_done   = head.block_done;
    assign o_parse_status = head.parse_status;

endmodule

// ===== sv/vct_parser.sv =====
// Byte parser: phase state, length fields, prefix matching and result formation.
module vct_parser #(
    parameter int TAG_CAPACITY = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_data_byte,
    input  logic [23:0]       i_block_size,
    output vct_pkg::t_push    o_push
);

    localparam int CW = $clog2(TAG_CAPACITY);
    localparam logic [CW-1:0] COPY_MAX = CW'(TAG_CAPACITY - 1);

    localparam logic [7:0] KEY_TEXT [3][8] = '{
        '{"t", "i", "t", "l", "e", "=", 8'h00, 8'h00},
        '{"a", "r", "t", "i", "s", "t", "=", 8'h00},
        '{"a", "l", "b", "u", "m", "=", 8'h00, 8'h00}
    };
    localparam logic [3:0] KEY_LEN [3] = '{4'd6, 4'd7, 4'd6};

    typedef enum logic [2:0] {
        PH_VLEN, PH_VSKIP, PH_COUNT, PH_CLEN, PH_BODY, PH_OK, PH_TRUNC
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [23:0]        r_len_acc, n_len_acc;
    logic [1:0]         r_len_idx, n_len_idx;
    logic [23:0]        r_consumed;
    logic [31:0]        r_comments, n_comments;
    logic [23:0]        r_field_left, n_field_left;
    logic [3:0]         r_prefix_pos, n_prefix_pos;
    logic [2:0]         r_cand, n_cand;
    vct_pkg::t_tag_kind r_active, n_active;
    logic [CW-1:0]      r_copied, n_copied;
    logic [2:0]         r_found, n_found;

    logic [24:0]        after;
    logic               is_final;
    logic [23:0]        rem;
    logic [31:0]        len_full;
    logic               len_done;
    logic               len_over;
    logic [7:0]         folded;
    logic               hit;
    logic               emit;
    logic               emit_last;
    vct_pkg::t_result   res_val;
    vct_pkg::t_result   res_done;

    function automatic logic [7:0] fold(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    always_comb begin
        after    = {1'b0, r_consumed} + 25'd1;
        is_final = after >= {1'b0, i_block_size};
        rem      = ({1'b0, i_block_size} > after) ? i_block_size - after[23:0] : 24'd0;
        len_full = {i_data_byte, r_len_acc};
        len_done = r_len_idx == 2'd3;
        len_over = len_full > {8'd0, rem};
        folded   = fold(i_data_byte);

        n_phase      = r_phase;
        n_len_acc    = r_len_acc;
        n_len_idx    = r_len_idx;
        n_comments   = r_comments;
        n_field_left = r_field_left;
        n_prefix_pos = r_prefix_pos;
        n_cand       = r_cand;
        n_active     = r_active;
        n_copied     = r_copied;
        n_found      = r_found;
        hit          = 1'b0;
        emit         = 1'b0;
        emit_last    = 1'b0;

        case (r_phase)
            PH_VLEN, PH_COUNT, PH_CLEN: begin
                n_len_idx = r_len_idx + 2'd1;
                case (r_len_idx)
                    2'd0:    n_len_acc = {r_len_acc[23:8], i_data_byte};
                    2'd1:    n_len_acc = {r_len_acc[23:16], i_data_byte, r_len_acc[7:0]};
                    2'd2:    n_len_acc = {i_data_byte, r_len_acc[15:0]};
                    default: n_len_acc = 24'd0;
                endcase
                if (len_done) begin
                    if (r_phase == PH_COUNT) begin
                        n_comments = len_full;
                        n_phase    = (len_full == 32'd0) ? PH_OK : PH_CLEN;
                    end else if (len_over) begin
                        n_phase = PH_TRUNC;
                    end else if (r_phase == PH_VLEN) begin
                        n_field_left = len_full[23:0];
                        n_phase      = (len_full == 32'd0) ? PH_COUNT : PH_VSKIP;
                    end else if (len_full == 32'd0) begin
                        n_comments = r_comments - 32'd1;
                        n_phase    = (n_comments == 32'd0) ? PH_OK : PH_CLEN;
                        n_active   = vct_pkg::TAG_NONE;
                        n_cand     = 3'd0;
                    end else begin
                        n_field_left = len_full[23:0];
                        n_phase      = PH_BODY;
                        n_prefix_pos = 4'd0;
                        n_active     = vct_pkg::TAG_NONE;
                        n_copied     = '0;
                        for (int k = 0; k < 3; k++) begin
                            n_cand[k] = (len_full > {28'd0, KEY_LEN[k]}) && !r_found[k];
                        end
                    end
                end
            end
            PH_VSKIP: begin
                n_field_left = r_field_left - 24'd1;
                if (n_field_left == 24'd0) begin
                    n_phase = PH_COUNT;
                end
            end
            PH_BODY: begin
                n_field_left = r_field_left - 24'd1;
                if (r_cand != 3'd0) begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_cand[k] && !hit) begin
                            if (r_prefix_pos >= KEY_LEN[k] ||
                                folded != KEY_TEXT[k][r_prefix_pos[2:0]]) begin
                                n_cand[k] = 1'b0;
                            end else if (r_prefix_pos == KEY_LEN[k] - 4'd1) begin
                                hit        = 1'b1;
                                n_active   = vct_pkg::t_tag_kind'(2'(k + 1));
                                n_found[k] = 1'b1;
                                n_copied   = '0;
                            end
                        end
                    end
                    if (hit) begin
                        n_cand = 3'd0;
                    end
                    if (r_prefix_pos < 4'd8) begin
                        n_prefix_pos = r_prefix_pos + 4'd1;
                    end
                end else if (r_active != vct_pkg::TAG_NONE && r_copied < COPY_MAX) begin
                    emit      = 1'b1;
                    n_copied  = r_copied + CW'(1);
                    emit_last = (n_copied == COPY_MAX) || (n_field_left == 24'd0);
                    if (emit_last) begin
                        n_active = vct_pkg::TAG_NONE;
                    end
                end
                if (n_field_left == 24'd0) begin
                    n_comments = r_comments - 32'd1;
                    n_phase    = (n_comments == 32'd0) ? PH_OK : PH_CLEN;
                    n_active   = vct_pkg::TAG_NONE;
                    n_cand     = 3'd0;
                end
            end
            default: begin
            end
        endcase

        res_val.tag_kind     = r_active;
        res_val.value_byte   = i_data_byte;
        res_val.value_last   = emit_last;
        res_val.block_done   = 1'b0;
        res_val.parse_status = vct_pkg::STATUS_FULL;

        res_done.tag_kind     = vct_pkg::TAG_NONE;
        res_done.value_byte   = 8'd0;
        res_done.value_last   = 1'b0;
        res_done.block_done   = 1'b1;
        res_done.parse_status = (n_phase == PH_OK) ? vct_pkg::STATUS_FULL
                                                   : vct_pkg::STATUS_TRUNC;

        o_push.r0  = emit ? res_val : res_done;
        o_push.r1  = res_done;
        o_push.num = i_take ? ({1'b0, emit} + {1'b0, is_final}) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && is_final)) begin
            r_phase      <= PH_VLEN;
            r_len_acc    <= 24'd0;
            r_len_idx    <= 2'd0;
            r_consumed   <= 24'd0;
            r_comments   <= 32'd0;
            r_field_left <= 24'd0;
            r_prefix_pos <= 4'd0;
            r_cand       <= 3'b111;
            r_active     <= vct_pkg::TAG_NONE;
            r_copied     <= '0;
            r_found      <= 3'd0;
        end else if (i_take) begin
            r_phase      <= n_phase;
            r_len_acc    <= n_len_acc;
            r_len_idx    <= n_len_idx;
            r_consumed   <= after[23:0];
            r_comments   <= n_comments;
            r_field_left <= n_field_left;
            r_prefix_pos <= n_prefix_pos;
            r_cand       <= n_cand;
            r_active     <= n_active;
            r_copied     <= n_copied;
            r_found      <= n_found;
        end
    end

endmodule

// ===== sv/vct_out_queue.sv =====
// Result queue that takes up to two results per cycle and hands out one.
module vct_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vct_pkg::t_push   i_push,
    input  logic             i_pop_ready,
    output logic             o_valid,
    output vct_pkg::t_result o_result,
    output logic             o_space
);

    vct_pkg::t_result                r_entry [vct_pkg::QUEUE_DEPTH];
    logic [vct_pkg::QPTR_W-1:0]      r_wr_ptr, r_rd_ptr;
    logic [vct_pkg::QCNT_W-1:0]      r_count, n_count;
    logic                            pop;

    always_comb begin
        o_valid  = r_count != '0;
        o_result = r_entry[r_rd_ptr];
        o_space  = r_count <= vct_pkg::QCNT_W'(vct_pkg::QUEUE_DEPTH - 2);
        pop      = o_valid && i_pop_ready;
        n_count  = r_count + vct_pkg::QCNT_W'(i_push.num) - vct_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_entry[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.num == 2'd2) begin
            r_entry[r_wr_ptr + vct_pkg::QPTR_W'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + vct_pkg::QPTR_W'(i_push.num);
            r_rd_ptr <= r_rd_ptr + vct_pkg::QPTR_W'(pop);
            r_count  <= n_count;
        end
    end

endmodule

// ===== sv/vct_checker.sv =====
// Port-level assertions for the tag extractor and their bind to the top level.
`include "vorbis_comment_tag_extractor_assert.svh"

module vct_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_tag_kind,
    input logic [7:0]  o_value_byte,
    input logic        o_value_last,
    input logic        o_block_done,
    input logic        o_parse_status
);

    `VCT_CHECK(a_done_clean, !(o_out_valid && o_block_done) || (o_tag_kind == vct_pkg::TAG_NONE && o_value_byte == 8'd0 && !o_value_last), "Done transaction carries value fields.")
    `VCT_CHECK(a_value_kind, !(o_out_valid && !o_block_done) || (o_tag_kind != vct_pkg::TAG_NONE && o_parse_status == vct_pkg::STATUS_FULL), "Value transaction has no tag or a status.")
    `VCT_CHECK_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable({o_tag_kind, o_value_byte, o_value_last, o_block_done, o_parse_status}), "Stalled result changed.")

endmodule

bind vorbis_comment_tag_extractor vct_checker u_vct_checker (.*);

// ===== sim/vorbis_comment_tag_extractor_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the Vorbis comment tag extractor with a byte-level parse predictor.
module vorbis_comment_tag_extractor_test;

    localparam int TAG_CAPACITY  = 64;
    localparam int RANDOM_BYTES  = 1600;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [2:0] {
        LEN_VENDOR,
        SKIP_VENDOR,
        READ_COUNT,
        LEN_COMMENT,
        COMMENT_BODY,
        PARSE_OK,
        PARSE_TRUNC
    } t_parse_phase;

    class tag_scoreboard;
        vct_pkg::t_result expected_q[$];
        int mismatches;
        int value_results;
        int done_results;
        int truncated_blocks;
        logic [23:0] block_size;
        t_parse_phase phase;
        logic [31:0] length_accum;
        logic [1:0] len_index;
        logic [23:0] bytes_consumed;
        logic [31:0] comments_left;
        logic [31:0] field_left;
        logic [3:0] prefix_pos;
        logic [2:0] candidates;
        logic [2:0] found;
        vct_pkg::t_tag_kind active_tag;
        logic [$clog2(TAG_CAPACITY)-1:0] copied;

        function new();
            block_size = '0;
            clear();
        endfunction

        static function string key_text(int k);
            case (k)
                0: return "title=";
                1: return "artist=";
                default: return "album=";
            endcase
        endfunction

        function void clear();
            phase = LEN_VENDOR;
            length_accum = '0;
            len_index = '0;
            bytes_consumed = '0;
            comments_left = '0;
            field_left = '0;
            prefix_pos = '0;
            candidates = 3'b111;
            active_tag = vct_pkg::TAG_NONE;
            copied = '0;
            found = '0;
        endfunction

        function void set_block_size(logic [23:0] v);
            block_size = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [7:0] fold(logic [7:0] c);
            return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        endfunction

        function bit take_length(logic [7:0] b);
            length_accum |= {24'b0, b} << (8 * len_index);
            len_index++;
            return len_index == 2'd0;
        endfunction

        function void end_comment();
            comments_left--;
            phase = (comments_left == 0) ? PARSE_OK : LEN_COMMENT;
            active_tag = vct_pkg::TAG_NONE;
            candidates = '0;
        endfunction

        function void note_byte(logic [7:0] b);
            logic [31:0] next_count;
            logic [31:0] rem;
            logic [31:0] len;
            bit last_byte;
            string key;
            vct_pkg::t_result r;
            next_count = {8'b0, bytes_consumed} + 32'd1;
            rem = ({8'b0, block_size} > next_count) ? {8'b0, block_size} - next_count : 32'd0;
            last_byte = next_count >= {8'b0, block_size};
            case (phase)
                LEN_VENDOR: begin
                    if (take_length(b)) begin
                        len = length_accum;
                        length_accum = '0;
                        if (len > rem) begin
                            phase = PARSE_TRUNC;
                        end else begin
                            field_left = len;
                            phase = (len == 0) ? READ_COUNT : SKIP_VENDOR;
                        end
                    end
                end
                SKIP_VENDOR: begin
                    field_left--;
                    if (field_left == 0) phase = READ_COUNT;
                end
                READ_COUNT: begin
                    if (take_length(b)) begin
                        comments_left = length_accum;
                        length_accum = '0;
                        phase = (comments_left == 0) ? PARSE_OK : LEN_COMMENT;
                    end
                end
                LEN_COMMENT: begin
                    if (take_length(b)) begin
                        len = length_accum;
                        length_accum = '0;
                        if (len > rem) begin
                            phase = PARSE_TRUNC;
                        end else if (len == 0) begin
                            end_comment();
                        end else begin
                            field_left = len;
                            phase = COMMENT_BODY;
                            prefix_pos = '0;
                            active_tag = vct_pkg::TAG_NONE;
                            copied = '0;
                            candidates = '0;
                            for (int k = 0; k < 3; k++) begin
                                key = key_text(k);
                                if (len > key.len() && !found[k]) candidates[k] = 1'b1;
                            end
                        end
                    end
                end
                COMMENT_BODY: begin
                    field_left--;
                    if (candidates != 0) begin
                        for (int k = 0; k < 3; k++) begin
                            key = key_text(k);
                            if (candidates[k]) begin
                                if (prefix_pos >= key.len() || fold(b) != key[prefix_pos]) begin
                                    candidates[k] = 1'b0;
                                end else if (prefix_pos == key.len() - 1) begin
                                    active_tag = vct_pkg::t_tag_kind'(k + 1);
                                    found[k] = 1'b1;
                                    copied = '0;
                                    candidates = '0;
                                end
                            end
                        end
                        if (prefix_pos < 8) prefix_pos++;
                    end else if (active_tag != vct_pkg::TAG_NONE &&
                                 copied < TAG_CAPACITY - 1) begin
                        copied++;
                        r.tag_kind = active_tag;
                        r.value_byte = b;
                        r.value_last = (copied == TAG_CAPACITY - 1) || (field_left == 0);
                        r.block_done = 1'b0;
                        r.parse_status = vct_pkg::STATUS_FULL;
                        expected_q.push_back(r);
                        if (r.value_last) active_tag = vct_pkg::TAG_NONE;
                    end
                    if (field_left == 0) end_comment();
                end
                default: begin
                end
            endcase
            bytes_consumed = next_count[23:0];
            if (last_byte) begin
                r.tag_kind = vct_pkg::TAG_NONE;
                r.value_byte = '0;
                r.value_last = 1'b0;
                r.block_done = 1'b1;
                r.parse_status = (phase == PARSE_OK) ? vct_pkg::STATUS_FULL
                                                     : vct_pkg::STATUS_TRUNC;
                expected_q.push_back(r);
                clear();
            end
        endfunction

        function void report(string what, vct_pkg::t_result want, vct_pkg::t_result got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s: expected kind %0d byte %02h last %0b done %0b status %0b,",
                         what, want.tag_kind, want.value_byte, want.value_last,
                         want.block_done, want.parse_status);
                $display("    got kind %0d byte %02h last %0b done %0b status %0b",
                         got.tag_kind, got.value_byte, got.value_last,
                         got.block_done, got.parse_status);
            end
        endfunction

        function void check_result(vct_pkg::t_result got);
            vct_pkg::t_result want;
            if (got.block_done) begin
                done_results++;
                if (got.parse_status) truncated_blocks++;
            end else begin
                value_results++;
            end
            if (expected_q.size() == 0) begin
                report("Unexpected result", '0, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.tag_kind !== want.tag_kind || got.value_byte !== want.value_byte ||
                    got.value_last !== want.value_last || got.block_done !== want.block_done ||
                    got.parse_status !== want.parse_status)
                report("Result mismatch", want, got);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [23:0] i_cfg_block_size = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_tag_kind;
    logic [7:0]  o_value_byte;
    logic        o_value_last;
    logic        o_block_done;
    logic        o_parse_status;

    tag_scoreboard sb;
    logic [7:0] blk[$];
    bit in_pace = 1'b1;
    bit out_pace = 1'b1;
    int bytes_sent = 0;
    int blocks_sent = 0;

    vorbis_comment_tag_extractor #(
        .TAG_CAPACITY(TAG_CAPACITY)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_block_size(i_cfg_block_size),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_data_byte(i_data_byte),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_tag_kind(o_tag_kind),
        .o_value_byte(o_value_byte),
        .o_value_last(o_value_last),
        .o_block_done(o_block_done),
        .o_parse_status(o_parse_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin : monitor
        vct_pkg::t_result got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_block_size(i_cfg_block_size);
            if (i_in_valid && o_in_ready) sb.note_byte(i_data_byte);
            if (o_out_valid && i_out_ready) begin
                got.tag_kind = vct_pkg::t_tag_kind'(o_tag_kind);
                got.value_byte = o_value_byte;
                got.value_last = o_value_last;
                got.block_done = o_block_done;
                got.parse_status = o_parse_status;
                sb.check_result(got);
            end
        end
    end

    initial begin : result_sink
        int gap;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = out_pace ? $urandom_range(0, 3) : 0;
            if (gap != 0) begin
                i_out_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    initial begin
        #2_000_000;
        $display("vorbis_comment_tag_extractor test failed");
        $finish;
    end

    task automatic write_size(logic [23:0] v);
        i_cfg_valid = 1'b1;
        i_cfg_block_size = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_range(int first, int count);
        int gap;
        for (int i = 0; i < count; i++) begin
            gap = in_pace ? $urandom_range(0, 3) : 0;
            if (gap != 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_in_valid = 1'b1;
            i_data_byte = blk[first + i];
            do @(posedge i_clk); while (!o_in_ready);
            @(negedge i_clk);
        end
        i_in_valid = 1'b0;
        bytes_sent += count;
    endtask

    task automatic settle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic push_le32(logic [31:0] v);
        blk.push_back(v[7:0]);
        blk.push_back(v[15:8]);
        blk.push_back(v[23:16]);
        blk.push_back(v[31:24]);
    endtask

    task automatic push_key(string key, int count);
        logic [7:0] c;
        for (int i = 0; i < count; i++) begin
            c = key[i];
            if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
            blk.push_back(c);
        end
    endtask

    task automatic add_comment();
        int kind;
        int vlen;
        int r;
        int cut;
        string key;
        kind = $urandom_range(0, 9);
        r = $urandom_range(0, 9);
        if (r == 0) vlen = 0;
        else if (r <= 6) vlen = $urandom_range(1, 8);
        else if (r == 7) vlen = $urandom_range(60, 70);
        else vlen = $urandom_range(9, 30);
        key = tag_scoreboard::key_text(kind % 3);
        case (kind)
            0, 1, 2, 3, 4: begin
                push_le32(key.len() + vlen);
                push_key(key, key.len());
                repeat (vlen) blk.push_back(8'($urandom));
            end
            5: begin
                cut = $urandom_range(1, key.len() - 1);
                push_le32(cut + 3);
                push_key(key, cut);
                repeat (3) blk.push_back(8'($urandom));
            end
            6: begin
                vlen = $urandom_range(0, 12);
                push_le32(vlen);
                repeat (vlen) blk.push_back(8'($urandom));
            end
            7: push_le32(0);
            8: push_le32($urandom | 32'h0001_0000);
            default: begin
                vlen = $urandom_range(1, 5);
                push_le32(vlen);
                repeat (vlen) blk.push_back(8'($urandom_range(32, 126)));
            end
        endcase
    endtask

    task automatic make_block(output logic [23:0] size);
        int n_vendor;
        int n_comments;
        int style;
        int n;
        logic [31:0] field;
        blk.delete();
        n_vendor = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        field = ($urandom_range(0, 19) == 0) ? ($urandom | 32'h0100_0000) : n_vendor;
        push_le32(field);
        repeat (n_vendor) blk.push_back(8'($urandom));
        n_comments = $urandom_range(0, 5);
        field = ($urandom_range(0, 9) == 0) ? $urandom : n_comments;
        push_le32(field);
        repeat (n_comments) add_comment();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) blk.push_back(8'($urandom));
        size = 24'(blk.size());
        style = $urandom_range(0, 15);
        if (style == 0) begin
            blk.delete();
            n = $urandom_range(1, 30);
            repeat (n) blk.push_back(8'($urandom));
            size = 24'(n);
        end else if (style == 1) begin
            blk.delete();
            repeat ($urandom_range(1, 4)) blk.push_back(8'($urandom));
            size = '0;
        end else if (style <= 3 && blk.size() > 1) begin
            size = 24'($urandom_range(1, blk.size() - 1));
        end
    endtask

    initial begin
        logic [23:0] size;
        int n;
        int k;
        sb = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_size(24'd0);
        blk = '{8'h00, 8'hFF};
        send_range(0, 2);
        settle();

        write_size(24'hFF_FFFF);
        blk = '{8'h80, 8'h7F, 8'h00, 8'h01};
        send_range(0, 3);
        settle();
        write_size(24'd2);
        send_range(3, 1);
        settle();

        blk.delete();
        push_le32(0);
        push_le32(2);
        push_le32(8);
        push_key("artist=", 7);
        blk.push_back("Z");
        push_le32(32'h00FF_FFFF);
        write_size(24'(blk.size()));
        send_range(0, blk.size());
        settle();

        while (bytes_sent < RANDOM_BYTES) begin
            make_block(size);
            n = (size == 0) ? blk.size() : size;
            in_pace = $urandom_range(0, 3) != 0;
            out_pace = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 7) == 0 && n > 1) begin
                write_size(24'($urandom));
                k = $urandom_range(1, n - 1);
                send_range(0, k);
                settle();
                write_size(size);
                send_range(k, n - k);
            end else begin
                write_size(size);
                send_range(0, n);
            end
            settle();
            blocks_sent++;
        end

        $display("Sent %0d bytes over %0d random blocks plus directed cases.",
                 bytes_sent, blocks_sent);
        $display("Checked %0d tag value bytes and %0d done results, %0d of them cut short.",
                 sb.value_results, sb.done_results, sb.truncated_blocks);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("vorbis_comment_tag_extractor test passed");
        end else begin
            $display("vorbis_comment_tag_extractor test failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/vct_pkg.sv
sv/vct_parser.sv
sv/vct_out_queue.sv
sv/vorbis_comment_tag_extractor.sv
sv/vct_checker.sv
sim/vorbis_comment_tag_extractor_test.sv
